// ----- src/vector_normalize_cross_macros.svh -----
// Assertion helpers shared by the queue and back RTL files.
// Both expect clk and arst_n in scope.
`ifndef VECTOR_NORMALIZE_CROSS_MACROS_SVH
`define VECTOR_NORMALIZE_CROSS_MACROS_SVH

// cond must never hold at a clock edge out of reset
`define VNC_AST_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// pre at one edge implies post at the next edge
`define VNC_AST_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- src/vnc_pkg.sv -----
`default_nettype none
package vnc_pkg;

	localparam int COMPONENT_BITS = 24;
	localparam int CB = COMPONENT_BITS;
	localparam int VW = 2 * CB + 1;     // signed cross product component
	localparam int MW = 2 * CB;         // component magnitude
	localparam int SW = 2 * MW;         // sum of squares
	localparam int RMW = MW + 2;        // square root partial remainder
	localparam int FRAC_OUT = 30;
	localparam int QW = FRAC_OUT + 1;   // quotient, up to 2^30
	localparam int OW = 32;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	typedef enum logic {
		OP_NORM  = 1'b0,
		OP_CROSS = 1'b1
	} op_t;

	typedef logic [2:0][VW-1:0] vec3_t;

	typedef struct packed {
		logic              zero;
		logic [2:0]        neg;
		logic [2:0][MW-1:0] mag;
		logic [SW-1:0]     sum;
		logic [RMW-1:0]    rem;
		logic [MW-1:0]     root;
	} sq_t;

	typedef struct packed {
		logic              zero;
		logic [2:0]        neg;
		logic [MW-1:0]     m;
		logic [2:0][QW-1:0] q;
		logic [2:0][MW:0]  r;
	} dv_t;

	// one digit pair of floor(sqrt(sum))
	function automatic sq_t sqrt_step(input sq_t s);
		sq_t o;
		logic [RMW-1:0] rem_n;
		logic [RMW-1:0] trial;
		o = s;
		rem_n = {s.rem[RMW-3:0], s.sum[SW-1 -: 2]};
		trial = {s.root, 2'b01};
		o.sum = {s.sum[SW-3:0], 2'b00};
		if (rem_n >= trial) begin
			o.rem = rem_n - trial;
			o.root = {s.root[MW-2:0], 1'b1};
		end else begin
			o.rem = rem_n;
			o.root = {s.root[MW-2:0], 1'b0};
		end
		return o;
	endfunction

	// integer bit of mag / m (mag <= m)
	function automatic dv_t div_init(input sq_t s);
		dv_t o;
		o.zero = s.zero;
		o.neg = s.neg;
		o.m = s.root;
		for (int i = 0; i < 3; i++) begin
			if (s.mag[i] >= s.root) begin
				o.q[i] = QW'(1);
				o.r[i] = {1'b0, s.mag[i]} - {1'b0, s.root};
			end else begin
				o.q[i] = '0;
				o.r[i] = {1'b0, s.mag[i]};
			end
		end
		return o;
	endfunction

	// one fraction bit per lane, restoring
	function automatic dv_t div_step(input dv_t s);
		dv_t o;
		logic [MW:0] r2;
		o = s;
		for (int i = 0; i < 3; i++) begin
			r2 = {s.r[i][MW-1:0], 1'b0};
			if (r2 >= {1'b0, s.m}) begin
				o.r[i] = r2 - {1'b0, s.m};
				o.q[i] = {s.q[i][QW-2:0], 1'b1};
			end else begin
				o.r[i] = r2;
				o.q[i] = {s.q[i][QW-2:0], 1'b0};
			end
		end
		return o;
	endfunction

endpackage
`default_nettype wire

// ----- src/vector_normalize_cross.sv -----
// Channel   Handshake          Payload
// input     push / full        op, ax, ay, az, bx, by, bz
// result    pop / empty        rx, ry, rz, zero_length
//
// One item per cycle sustained while results are popped.
// Most of the back pipeline is the square root (one root bit per stage) and the 31-stage divider lanes.
// Front: two stages (products, cross/select) feeding a four-entry queue.
// A held result freezes the back pipeline; the queue lets the front keep accepting.
// Asynchronous reset clears only valid bits and the queue pointers and count.
`default_nettype none
module vector_normalize_cross import vnc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 op,
	input  logic signed [CB-1:0] ax,
	input  logic signed [CB-1:0] ay,
	input  logic signed [CB-1:0] az,
	input  logic signed [CB-1:0] bx,
	input  logic signed [CB-1:0] by,
	input  logic signed [CB-1:0] bz,
	output logic                 empty,
	input  logic                 pop,
	output logic signed [OW-1:0] rx,
	output logic signed [OW-1:0] ry,
	output logic signed [OW-1:0] rz,
	output logic                 zero_length
);

	logic  q_push, q_full, q_pop, q_empty;
	vec3_t q_wdata, q_rdata;

	vnc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.op     (op),
		.ax     (ax),
		.ay     (ay),
		.az     (az),
		.bx     (bx),
		.by     (by),
		.bz     (bz),
		.q_push (q_push),
		.q_full (q_full),
		.q_data (q_wdata)
	);

	vnc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	vnc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.rx          (rx),
		.ry          (ry),
		.rz          (rz),
		.zero_length (zero_length)
	);

endmodule
`default_nettype wire

// ----- src/vnc_front.sv -----
`default_nettype none
module vnc_front import vnc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 op,
	input  logic signed [CB-1:0] ax,
	input  logic signed [CB-1:0] ay,
	input  logic signed [CB-1:0] az,
	input  logic signed [CB-1:0] bx,
	input  logic signed [CB-1:0] by,
	input  logic signed [CB-1:0] bz,
	output logic                 q_push,
	input  logic                 q_full,
	output vec3_t                q_data
);

	logic                 vld_s1, vld_s2;
	op_t                  op_s1;
	logic signed [CB-1:0] a_s1 [3];
	logic signed [MW-1:0] prod_s1 [6];
	vec3_t                v_s2;
	vec3_t                v_nxt;
	logic                 s1_free, s2_free, acc;

	assign s2_free = !vld_s2 || !q_full;
	assign s1_free = !vld_s1 || s2_free;
	assign full = !s1_free;
	assign acc = push && s1_free;
	assign q_push = vld_s2 && !q_full;
	assign q_data = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s1_free)
				vld_s1 <= acc;
			if (s2_free)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1 <= op_t'(op);
			a_s1[0] <= ax;
			a_s1[1] <= ay;
			a_s1[2] <= az;
			prod_s1[0] <= ay * bz;
			prod_s1[1] <= az * by;
			prod_s1[2] <= az * bx;
			prod_s1[3] <= ax * bz;
			prod_s1[4] <= ax * by;
			prod_s1[5] <= ay * bx;
		end
		if (s2_free && vld_s1)
			v_s2 <= v_nxt;
	end

	always_comb begin
		unique case (op_s1)
			OP_CROSS: begin
				for (int i = 0; i < 3; i++)
					v_nxt[i] = {prod_s1[2*i][MW-1], prod_s1[2*i]}
						- {prod_s1[2*i+1][MW-1], prod_s1[2*i+1]};
			end
			default: begin
				for (int i = 0; i < 3; i++)
					v_nxt[i] = {{(VW-CB){a_s1[i][CB-1]}}, a_s1[i]};
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- src/vnc_queue.sv -----
`default_nettype none
`include "vector_normalize_cross_macros.svh"
module vnc_queue import vnc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  vec3_t wdata,
	input  logic  pop,
	output logic  empty,
	output vec3_t rdata
);

	vec3_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QCW-1:0] cnt_q;

	assign full = (cnt_q == QCW'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	`VNC_AST_NEVER(a_push_full, push && full, "queue request while full")
	`VNC_AST_NEVER(a_pop_empty, pop && empty, "queue pop while empty")
	`VNC_AST_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count slip")

endmodule
`default_nettype wire

// ----- src/vnc_back.sv -----
`default_nettype none
`include "vector_normalize_cross_macros.svh"
module vnc_back import vnc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  vec3_t                q_data,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic signed [OW-1:0] rx,
	output logic signed [OW-1:0] ry,
	output logic signed [OW-1:0] rz,
	output logic                 zero_length
);

	logic                en;
	logic                vld_s1, vld_s2, vld_s3;
	logic [2:0]          neg_s1, neg_s2, neg_s3;
	logic [2:0][MW-1:0]  mag_s1, mag_s2, mag_s3;
	logic                zero_s2, zero_s3;
	logic [2:0][MW-1:0]  hh_s2, hl_s2, ll_s2;
	logic [2:0][SW-1:0]  sqr_s3;
	logic [2:0]          neg_nxt;
	logic [2:0][MW-1:0]  mag_nxt;
	sq_t                 sq_s [MW+1];
	logic [MW:0]         sq_vld_s;
	dv_t                 dv_s [FRAC_OUT+1];
	logic [FRAC_OUT:0]   dv_vld_s;
	logic                out_vld_q;
	logic [2:0][OW-1:0]  res_q;
	logic                zl_q;
	dv_t                 fin;

	// whole back pipeline freezes while the result register is held
	assign en = !out_vld_q || pop;
	assign q_pop = en && !q_empty;
	assign empty = !out_vld_q;
	assign rx = res_q[0];
	assign ry = res_q[1];
	assign rz = res_q[2];
	assign zero_length = zl_q;
	assign fin = dv_s[FRAC_OUT];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_nxt[i] = q_data[i][VW-1];
			mag_nxt[i] = neg_nxt[i] ? MW'(VW'(0) - q_data[i]) : q_data[i][MW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			sq_vld_s <= '0;
			dv_vld_s <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= !q_empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			sq_vld_s <= {sq_vld_s[MW-1:0], vld_s3};
			dv_vld_s <= {dv_vld_s[FRAC_OUT-1:0], sq_vld_s[MW]};
			out_vld_q <= dv_vld_s[FRAC_OUT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= neg_nxt;
			mag_s1 <= mag_nxt;

			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
			zero_s2 <= (mag_s1 == '0);
			for (int i = 0; i < 3; i++) begin
				hh_s2[i] <= mag_s1[i][MW-1:CB] * mag_s1[i][MW-1:CB];
				hl_s2[i] <= mag_s1[i][MW-1:CB] * mag_s1[i][CB-1:0];
				ll_s2[i] <= mag_s1[i][CB-1:0] * mag_s1[i][CB-1:0];
			end

			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			zero_s3 <= zero_s2;
			for (int i = 0; i < 3; i++)
				sqr_s3[i] <= (SW'(hh_s2[i]) << MW) + (SW'(hl_s2[i]) << (CB + 1))
					+ SW'(ll_s2[i]);

			sq_s[0].zero <= zero_s3;
			sq_s[0].neg <= neg_s3;
			sq_s[0].mag <= mag_s3;
			sq_s[0].sum <= sqr_s3[0] + sqr_s3[1] + sqr_s3[2];
			sq_s[0].rem <= '0;
			sq_s[0].root <= '0;
			for (int k = 1; k <= MW; k++)
				sq_s[k] <= sqrt_step(sq_s[k-1]);

			dv_s[0] <= div_init(sq_s[MW]);
			for (int k = 1; k <= FRAC_OUT; k++)
				dv_s[k] <= div_step(dv_s[k-1]);

			zl_q <= fin.zero;
			for (int i = 0; i < 3; i++) begin
				if (fin.zero)
					res_q[i] <= '0;
				else if (fin.neg[i])
					res_q[i] <= OW'(0) - OW'(fin.q[i]);
				else
					res_q[i] <= OW'(fin.q[i]);
			end
		end
	end

	`VNC_AST_NEVER(a_zero_out, out_vld_q && zl_q && (res_q != '0), "zero length with nonzero result")
	`VNC_AST_NEXT(a_hold, out_vld_q && !pop, out_vld_q && $stable(res_q), "held result changed")
	`VNC_AST_NEVER(a_pop_q, q_pop && !en, "queue popped during stall")

endmodule
`default_nettype wire

// ----- test/vector_normalize_cross_tb.sv -----
`default_nettype none
module vector_normalize_cross_tb;
	import vnc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [OW-1:0] x;
		logic signed [OW-1:0] y;
		logic signed [OW-1:0] z;
		logic                 zl;
	} unit_vec_t;

	localparam logic signed [CB-1:0] MAX_C = CB'((1 << (CB - 1)) - 1);
	localparam logic signed [CB-1:0] MIN_C = CB'(-(1 << (CB - 1)));
	localparam logic signed [CB-1:0] ONE_C = CB'(1 << 16);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic op = 1'b0;
	logic signed [CB-1:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [OW-1:0] rx, ry, rz;
	logic zero_length;

	unit_vec_t unit_queue[$];
	int errors = 0;
	int sent = 0;
	int got = 0;
	int zero_seen = 0;
	int cross_sent = 0;

	vector_normalize_cross dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("tb: failure");
		$finish;
	end

	// floor(sqrt(s)) by digit pairs
	function automatic logic [95:0] root_floor(input logic [191:0] s);
		logic [97:0] rem;
		logic [97:0] trial;
		logic [95:0] root;
		rem = '0;
		root = '0;
		for (int i = 95; i >= 0; i--) begin
			rem = {rem[95:0], s[2*i +: 2]};
			trial = {root, 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[94:0], 1'b1};
			end else begin
				root = {root[94:0], 1'b0};
			end
		end
		return root;
	endfunction

	function automatic unit_vec_t predict_unit(input logic o,
			input logic signed [CB-1:0] a0, a1, a2, b0, b1, b2);
		logic signed [63:0] v[3];
		logic [63:0] mag[3];
		logic [191:0] sumsq;
		logic [95:0] m;
		logic [159:0] q;
		logic signed [OW-1:0] c[3];
		unit_vec_t u;
		if (o == OP_NORM) begin
			v[0] = a0; v[1] = a1; v[2] = a2;
		end else begin
			v[0] = 64'(a1) * 64'(b2) - 64'(a2) * 64'(b1);
			v[1] = 64'(a2) * 64'(b0) - 64'(a0) * 64'(b2);
			v[2] = 64'(a0) * 64'(b1) - 64'(a1) * 64'(b0);
		end
		sumsq = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i][63] ? -v[i] : v[i];
			sumsq = sumsq + 192'(mag[i]) * 192'(mag[i]);
		end
		if (sumsq == 0) begin
			u = '{x: '0, y: '0, z: '0, zl: 1'b1};
			return u;
		end
		m = root_floor(sumsq);
		for (int i = 0; i < 3; i++) begin
			q = (160'(mag[i]) << FRAC_OUT) / 160'(m);
			c[i] = v[i][63] ? -OW'(q) : OW'(q);
		end
		u = '{x: c[0], y: c[1], z: c[2], zl: 1'b0};
		return u;
	endfunction

	task automatic report_mismatch(input string what, input logic [OW-1:0] seen, exp);
		errors++;
		$display("mismatch %s: got %0h expected %0h (result %0d)", what, seen, exp, got);
	endtask

	// push stays high from one request to the next when there is no gap
	task automatic send_request(input logic o, input logic signed [CB-1:0] a0, a1, a2,
			b0, b1, b2);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		op <= o;
		ax <= a0; ay <= a1; az <= a2;
		bx <= b0; by <= b1; bz <= b2;
		@(posedge clk);
		while (full) @(posedge clk);
		unit_queue.push_back(predict_unit(o, a0, a1, a2, b0, b1, b2));
		sent++;
		if (o == OP_CROSS) cross_sent++;
	endtask

	// result side: random stalls, compare with oldest expectation
	initial begin
		unit_vec_t e;
		int stall;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 11) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
			if ((got / 200) % 2 == 1) stall = 0;
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			got++;
			if (unit_queue.size() == 0) begin
				errors++;
				$display("unexpected result %0d", got);
			end else begin
				e = unit_queue.pop_front();
				if (zero_length) zero_seen++;
				if (rx !== e.x) report_mismatch("rx", rx, e.x);
				if (ry !== e.y) report_mismatch("ry", ry, e.y);
				if (rz !== e.z) report_mismatch("rz", rz, e.z);
				if (zero_length !== e.zl) report_mismatch("zero_length", zero_length, e.zl);
			end
		end
	end

	function automatic logic signed [CB-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return CB'($urandom_range(0, 3)) - CB'(1);
			1: return $urandom_range(0, 1) ? MAX_C : MIN_C;
			2: return CB'($signed($urandom_range(0, 511)) - 256);
			default: return CB'($urandom);
		endcase
	endfunction

	task automatic wait_drained();
		push <= 1'b0;
		while (unit_queue.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_request(OP_NORM, 0, 0, 0, 5, 6, 7);
		send_request(OP_NORM, ONE_C, 0, 0, 0, 0, 0);
		send_request(OP_NORM, 0, -ONE_C, 0, 0, 0, 0);
		send_request(OP_NORM, 0, 0, ONE_C, 0, 0, 0);
		send_request(OP_NORM, MAX_C, MAX_C, MAX_C, 0, 0, 0);
		send_request(OP_NORM, MIN_C, MIN_C, MIN_C, 0, 0, 0);
		send_request(OP_NORM, MIN_C, MAX_C, 1, 0, 0, 0);
		send_request(OP_NORM, 1, 0, 0, 0, 0, 0);
		send_request(OP_NORM, -1, -1, -1, 0, 0, 0);
		send_request(OP_NORM, 3, 4, 0, 0, 0, 0);
		send_request(OP_CROSS, ONE_C, 0, 0, 0, ONE_C, 0);
		send_request(OP_CROSS, ONE_C, 2, 3, ONE_C, 2, 3);
		send_request(OP_CROSS, 0, 0, 0, MAX_C, MIN_C, 1);
		send_request(OP_CROSS, MIN_C, MIN_C, MIN_C, MAX_C, MIN_C, MAX_C);
		send_request(OP_CROSS, MAX_C, MIN_C, 0, MIN_C, MAX_C, MAX_C);
		send_request(OP_CROSS, MIN_C, 0, 0, 0, MIN_C, 0);
		send_request(OP_CROSS, 1, 0, 0, 0, 1, 0);
		send_request(OP_CROSS, 2, 4, 6, -1, -2, -3);
	endtask

	task automatic test_random(input int count);
		logic signed [CB-1:0] c[6];
		int k;
		for (int n = 0; n < count; n++) begin
			foreach (c[i]) c[i] = rand_comp();
			// parallel vectors now and then
			if ($urandom_range(0, 15) == 0) begin
				k = int'($urandom_range(0, 6)) - 3;
				c[3] = CB'(c[0] * k); c[4] = CB'(c[1] * k); c[5] = CB'(c[2] * k);
			end
			send_request(logic'($urandom_range(0, 1)), c[0], c[1], c[2], c[3], c[4], c[5]);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_random(700);
		wait_drained();
		test_random(630);
		wait_drained();
		repeat (4 * CB + 60) @(posedge clk);
		$display("covered %0d requests (%0d cross products), %0d results, %0d zero length",
			sent, cross_sent, got, zero_seen);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire
